// ----- rtl/mp3ss_pkg.sv -----
package mp3ss_pkg;

    localparam int BYTE_BITS         = 8;
    localparam int FRAME_BITS        = 11;
    localparam int POS_BITS          = 4;
    localparam int TAG_BODY_BITS     = 28;
    localparam int SKIP_BITS_DEFAULT = 29;

    localparam int NUM_CLASSES = 3;
    localparam int NUM_RATES   = 16;
    localparam int NUM_FREQS   = 4;
    localparam int TBL_DEPTH   = NUM_CLASSES * NUM_RATES * NUM_FREQS;
    localparam int TBL_IDX_BITS = $clog2(TBL_DEPTH);

    localparam logic [1:0] CLS_FULL    = 2'd0;
    localparam logic [1:0] CLS_HALF    = 2'd1;
    localparam logic [1:0] CLS_QUARTER = 2'd2;

    localparam logic [BYTE_BITS-1:0] BYTE_ID3_I = 8'h49;
    localparam logic [BYTE_BITS-1:0] BYTE_ID3_D = 8'h44;
    localparam logic [BYTE_BITS-1:0] BYTE_ID3_3 = 8'h33;
    localparam logic [BYTE_BITS-1:0] BYTE_SYNC  = 8'hff;

    localparam int unsigned RATE_FULL [NUM_RATES] = '{
        0, 32000, 40000, 48000, 56000, 64000, 80000, 96000,
        112000, 128000, 160000, 192000, 224000, 256000, 320000, 0};
    localparam int unsigned RATE_LOW [NUM_RATES] = '{
        0, 8000, 16000, 24000, 32000, 40000, 48000, 56000,
        64000, 80000, 96000, 112000, 128000, 144000, 160000, 0};
    localparam int unsigned FREQ_DIV [NUM_FREQS] = '{44100, 48000, 32000, 1};
    localparam int unsigned CLASS_SCALE [NUM_CLASSES] = '{144, 144, 288};

    typedef struct packed {
        logic load_ver;
        logic store_tag6;
        logic store_tag7;
        logic store_tag8;
        logic load_skip;
        logic dec_skip;
        logic load_frame;
        logic dec_frame;
    } dp_cmd_t;

    typedef struct packed {
        logic is_id3_i;
        logic is_id3_d;
        logic is_id3_3;
        logic is_sync;
        logic msb_set;
        logic byte1_ok;
        logic byte2_ok;
        logic frame_short;
        logic body_zero;
        logic skip_one;
        logic frame_zero;
        logic frame_one;
    } dp_stat_t;

endpackage

// ----- rtl/mp3ss_dp.sv -----
module mp3ss_dp
    import mp3ss_pkg::*;
#(
    parameter int SKIP_COUNTER_BITS = SKIP_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic [BYTE_BITS-1:0] data_byte,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat
);

    logic [1:0]                   ver_reg, ver_next;
    logic [6:0]                   tag6_reg, tag6_next;
    logic [6:0]                   tag7_reg, tag7_next;
    logic [6:0]                   tag8_reg, tag8_next;
    logic [SKIP_COUNTER_BITS-1:0] skip_reg, skip_next;
    logic [FRAME_BITS-1:0]        frame_reg, frame_next;

    logic [FRAME_BITS-1:0]        frame_tbl [TBL_DEPTH];
    logic [1:0]                   cls;
    logic [TBL_IDX_BITS-1:0]      tbl_idx;
    logic [FRAME_BITS-1:0]        frame_len;
    logic [TAG_BODY_BITS-1:0]     body;
    logic [SKIP_COUNTER_BITS-1:0] skip_load;

    for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_cls
        for (genvar r = 0; r < NUM_RATES; r++) begin : g_rate
            for (genvar f = 0; f < NUM_FREQS; f++) begin : g_freq
                localparam int unsigned Rate = (c == 0) ? RATE_FULL[r] : RATE_LOW[r];
                localparam int unsigned Size =
                    (f == NUM_FREQS - 1) ? 0 : (Rate * CLASS_SCALE[c]) / FREQ_DIV[f];
                assign frame_tbl[(c * NUM_RATES + r) * NUM_FREQS + f] = FRAME_BITS'(Size);
            end
        end
    end

    always_comb begin
        if (ver_reg[0]) begin
            cls = CLS_FULL;
        end else if (ver_reg[1]) begin
            cls = CLS_HALF;
        end else begin
            cls = CLS_QUARTER;
        end
    end

    assign tbl_idx   = TBL_IDX_BITS'({cls, data_byte[7:4], data_byte[3:2]});
    assign frame_len = frame_tbl[tbl_idx] + FRAME_BITS'(data_byte[1]);

    assign body = {tag6_reg, tag7_reg, tag8_reg, 7'd0} | TAG_BODY_BITS'(data_byte);

    if (SKIP_COUNTER_BITS >= TAG_BODY_BITS) begin : g_skip_wide
        assign skip_load = SKIP_COUNTER_BITS'(body);
    end else begin : g_skip_sat
        assign skip_load = (|body[TAG_BODY_BITS-1:SKIP_COUNTER_BITS]) ?
                           {SKIP_COUNTER_BITS{1'b1}} : body[SKIP_COUNTER_BITS-1:0];
    end

    always_comb begin
        stat.is_id3_i    = data_byte == BYTE_ID3_I;
        stat.is_id3_d    = data_byte == BYTE_ID3_D;
        stat.is_id3_3    = data_byte == BYTE_ID3_3;
        stat.is_sync     = data_byte == BYTE_SYNC;
        stat.msb_set     = data_byte[7];
        stat.byte1_ok    = (data_byte[7:5] == 3'b111) && (data_byte[2:1] == 2'b01);
        stat.byte2_ok    = (data_byte[7:4] != 4'hf) && (data_byte[3:2] != 2'b11);
        stat.frame_short = frame_len < FRAME_BITS'(4);
        stat.body_zero   = skip_load == '0;
        stat.skip_one    = skip_reg == SKIP_COUNTER_BITS'(1);
        stat.frame_zero  = frame_reg == '0;
        stat.frame_one   = frame_reg == FRAME_BITS'(1);
    end

    always_comb begin
        ver_next   = ver_reg;
        tag6_next  = tag6_reg;
        tag7_next  = tag7_reg;
        tag8_next  = tag8_reg;
        skip_next  = skip_reg;
        frame_next = frame_reg;
        if (cmd.load_ver) begin
            ver_next = data_byte[4:3];
        end
        if (cmd.store_tag6) begin
            tag6_next = data_byte[6:0];
        end
        if (cmd.store_tag7) begin
            tag7_next = data_byte[6:0];
        end
        if (cmd.store_tag8) begin
            tag8_next = data_byte[6:0];
        end
        if (cmd.load_skip) begin
            skip_next = skip_load;
        end else if (cmd.dec_skip) begin
            skip_next = skip_reg - SKIP_COUNTER_BITS'(1);
        end
        if (cmd.load_frame) begin
            frame_next = frame_len - FRAME_BITS'(4);
        end else if (cmd.dec_frame) begin
            frame_next = frame_reg - FRAME_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        ver_reg   <= ver_next;
        tag6_reg  <= tag6_next;
        tag7_reg  <= tag7_next;
        tag8_reg  <= tag8_next;
        skip_reg  <= skip_next;
        frame_reg <= frame_next;
    end

endmodule

// ----- rtl/mp3ss_ctrl.sv -----
module mp3ss_ctrl
    import mp3ss_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     s_tlast,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output logic     m_verdict,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [2:0] PH_START     = 3'd0;
    localparam logic [2:0] PH_TAG       = 3'd1;
    localparam logic [2:0] PH_TAGSKIP   = 3'd2;
    localparam logic [2:0] PH_HDR1      = 3'd3;
    localparam logic [2:0] PH_FRAMESKIP = 3'd4;
    localparam logic [2:0] PH_HDR2      = 3'd5;
    localparam logic [2:0] PH_TAIL      = 3'd6;

    logic [2:0]          phase_reg, phase_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic                decided_reg, decided_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                verdict_reg, verdict_next;

    logic                fire;
    logic                res_valid;
    logic                res_value;
    logic                undecided;
    logic                fail;
    logic                pass;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign fire      = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_verdict = verdict_reg;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        cmd        = '0;
        undecided  = 1'b0;
        fail       = 1'b0;
        pass       = 1'b0;
        unique case (phase_reg)
            PH_START: begin
                pos_next = POS_BITS'(1);
                if (stat.is_id3_i) begin
                    phase_next = PH_TAG;
                end else if (stat.is_sync) begin
                    phase_next = PH_HDR1;
                end else begin
                    fail = 1'b1;
                end
            end
            PH_TAG: begin
                cmd.store_tag6 = pos_reg == POS_BITS'(6);
                cmd.store_tag7 = pos_reg == POS_BITS'(7);
                cmd.store_tag8 = pos_reg == POS_BITS'(8);
                if ((pos_reg == POS_BITS'(1) && !stat.is_id3_d) ||
                    (pos_reg == POS_BITS'(2) && !stat.is_id3_3) ||
                    ((pos_reg == POS_BITS'(3) || pos_reg == POS_BITS'(4)) && stat.is_sync) ||
                    (pos_reg >= POS_BITS'(6) && pos_reg <= POS_BITS'(8) && stat.msb_set) ||
                    pos_reg > POS_BITS'(9)) begin
                    fail = 1'b1;
                end else if (pos_reg < POS_BITS'(9)) begin
                    pos_next = pos_reg + POS_BITS'(1);
                end else begin
                    cmd.load_skip = 1'b1;
                    pos_next      = '0;
                    phase_next    = stat.body_zero ? PH_START : PH_TAGSKIP;
                end
            end
            PH_TAGSKIP: begin
                cmd.dec_skip = 1'b1;
                if (stat.skip_one) begin
                    phase_next = PH_START;
                end
            end
            PH_HDR1: begin
                if (pos_reg == POS_BITS'(1)) begin
                    cmd.load_ver = 1'b1;
                    fail         = !stat.byte1_ok;
                    pos_next     = pos_reg + POS_BITS'(1);
                end else if (pos_reg == POS_BITS'(2)) begin
                    cmd.load_frame = 1'b1;
                    fail           = !stat.byte2_ok || stat.frame_short;
                    pos_next       = pos_reg + POS_BITS'(1);
                end else if (pos_reg == POS_BITS'(3)) begin
                    pos_next   = '0;
                    phase_next = stat.frame_zero ? PH_HDR2 : PH_FRAMESKIP;
                end else begin
                    fail = 1'b1;
                end
            end
            PH_FRAMESKIP: begin
                cmd.dec_frame = 1'b1;
                if (stat.frame_one) begin
                    phase_next = PH_HDR2;
                    pos_next   = '0;
                end
            end
            PH_HDR2: begin
                pos_next = pos_reg + POS_BITS'(1);
                if (pos_reg == POS_BITS'(0)) begin
                    fail = !stat.is_sync;
                end else if (pos_reg == POS_BITS'(1)) begin
                    fail = !stat.byte1_ok;
                end else if (pos_reg == POS_BITS'(2)) begin
                    fail = !stat.byte2_ok;
                end else if (pos_reg == POS_BITS'(3)) begin
                    phase_next = PH_TAIL;
                end else begin
                    fail = 1'b1;
                end
            end
            PH_TAIL: begin
                pass = 1'b1;
            end
            default: begin
                fail = 1'b1;
            end
        endcase
        undecided = !fail && !pass;

        if (!fire || decided_reg) begin
            cmd        = '0;
            phase_next = phase_reg;
            pos_next   = pos_reg;
        end
    end

    always_comb begin
        res_valid    = 1'b0;
        res_value    = pass;
        decided_next = decided_reg;
        if (fire) begin
            if (decided_reg) begin
                if (s_tlast) begin
                    decided_next = 1'b0;
                end
            end else if (!undecided || s_tlast) begin
                res_valid    = 1'b1;
                decided_next = !s_tlast;
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        verdict_next  = verdict_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
            verdict_next  = res_value;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_START;
            pos_reg      <= '0;
            decided_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            phase_reg    <= PH_START;
            pos_reg      <= '0;
            decided_reg  <= decided_next;
            m_tvalid_reg <= m_tvalid_next;
        end else begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            decided_reg  <= decided_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        verdict_reg <= verdict_next;
    end

endmodule

// ----- rtl/mp3_stream_sniffer_top.sv -----
// The block reads a buffer one byte per transaction on the slave channel, with
// s_tlast high on the final byte, and gives one verdict per buffer on the master
// channel: 1 if the buffer starts like an MPEG audio layer III stream, else 0.
// Leading ID3v2 tags are skipped, then two consecutive valid frame headers are
// required, with at least one byte after the four bytes of the second header.
// A verdict of 0 is given at the first byte that fails a check, or at the last
// byte if nothing was decided earlier; bytes after the verdict are dropped up to
// and including the last byte of that buffer.
// One byte is taken per cycle while s_tready is high; the frame length comes
// from a constant table in the same cycle as the third header byte, so no byte
// ever waits on it. The verdict appears in the cycle after the byte that
// decides it and is held in an output register until it is taken. s_tready is
// low whenever a verdict is held and m_tready is low, so a stalling receiver
// halts the byte stream; a verdict taken in a cycle frees the register for a
// verdict decided in that same cycle. Synchronous reset drops any pending
// verdict and returns to the start of a buffer.
module mp3_stream_sniffer_top
    import mp3ss_pkg::*;
#(
    parameter int SKIP_COUNTER_BITS = SKIP_BITS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] verdict, [7:1] zero
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     verdict;

    mp3ss_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tlast   (s_tlast),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_verdict (verdict),
        .stat      (stat),
        .cmd       (cmd)
    );

    mp3ss_dp #(
        .SKIP_COUNTER_BITS (SKIP_COUNTER_BITS)
    ) u_dp (
        .aclk      (aclk),
        .data_byte (s_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign m_tdata = {7'd0, verdict};

endmodule

// ----- rtl/mp3ss_checker.sv -----
module mp3ss_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A held verdict stays put until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("verdict changed or vanished while stalled");

    // A new verdict only follows an accepted byte.
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("verdict appeared without an accepted byte");

    // With no verdict held the input side is always open.
    a_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");

    // The padding bits of the verdict are zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:1] == 7'd0)
        else $error("verdict padding not zero");

    // Leaving reset, nothing is pending.
    a_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid)
        else $error("verdict pending straight after reset");

endmodule

bind mp3_stream_sniffer_top mp3ss_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/tb_mp3_stream_sniffer_top.sv -----
`timescale 1ns / 100ps

module tb_mp3_stream_sniffer_top;
    import mp3ss_pkg::*;

    typedef enum logic [1:0] {
        TRAFFIC_FULL,
        TRAFFIC_SEND_GAPS,
        TRAFFIC_RECV_STALLS,
        TRAFFIC_BOTH
    } traffic_t;

    typedef enum logic [2:0] {
        SN_START,
        SN_TAG,
        SN_TAGSKIP,
        SN_HDR1,
        SN_FRAMESKIP,
        SN_HDR2,
        SN_TAIL
    } sniff_phase_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        traffic_t   mode;
    } sniff_item_t;

    localparam int unsigned BITRATE_V1 [16] = '{
        0, 32000, 40000, 48000, 56000, 64000, 80000, 96000,
        112000, 128000, 160000, 192000, 224000, 256000, 320000, 0};
    localparam int unsigned BITRATE_V2 [16] = '{
        0, 8000, 16000, 24000, 32000, 40000, 48000, 56000,
        64000, 80000, 96000, 112000, 128000, 144000, 160000, 0};
    localparam int unsigned SAMPLE_HZ [4] = '{44100, 48000, 32000, 0};

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    sniff_item_t byte_feed [$];
    logic        verdicts_due [$];
    traffic_t    traffic_mode = TRAFFIC_FULL;
    int          fail_count = 0;
    int          long_frames = 0;

    sniff_phase_t                 sn_phase;
    logic [7:0]                   sn_hdr [10];
    logic [3:0]                   sn_pos;
    logic [SKIP_BITS_DEFAULT-1:0] sn_skip;
    logic [10:0]                  sn_flen;
    logic                         sn_decided;

    sniff_item_t     drv_item;
    int unsigned     gap_pct;
    int unsigned     stall_pct;
    logic            want_verdict;

    mp3_stream_sniffer_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic bit sync_byte_ok(input logic [3:0] idx, input logic [7:0] b);
        if (idx == 4'd0) return b == BYTE_SYNC;
        if (idx == 4'd1) return b[7:5] == 3'b111 && b[2:1] == 2'b01;
        if (idx == 4'd2) return b[7:4] != 4'hf && b[3:2] != 2'b11;
        return 1'b1;
    endfunction

    function automatic int unsigned frame_bytes(input logic [7:0] b1, input logic [7:0] b2);
        logic [1:0]  ver;
        int unsigned rate;
        int unsigned hz;
        int unsigned nbytes;
        ver  = b1[4:3];
        rate = ver[0] ? BITRATE_V1[b2[7:4]] : BITRATE_V2[b2[7:4]];
        hz   = SAMPLE_HZ[b2[3:2]];
        if (ver == 2'd2) begin
            hz = hz >> 1;
        end else if (ver == 2'd0) begin
            hz = hz >> 2;
        end
        if (hz == 0) return 0;
        nbytes = rate * (ver[0] ? 144 : 72) / hz;
        if (b2[1]) nbytes = nbytes + 1;
        return nbytes;
    endfunction

    task automatic sniff_clear();
        sn_phase = SN_START;
        foreach (sn_hdr[i]) sn_hdr[i] = 8'h00;
        sn_pos     = 4'd0;
        sn_skip    = '0;
        sn_flen    = 11'd0;
        sn_decided = 1'b0;
    endtask

    // Returns the verdict decided by this byte, or -1 while still undecided.
    function automatic int sniff_consume(input logic [7:0] b);
        logic [3:0]        idx;
        longint unsigned   body;
        longint unsigned   cap;
        int unsigned       nbytes;
        idx = sn_pos;
        case (sn_phase)
            SN_START: begin
                sn_hdr[0] = b;
                sn_pos = 4'd1;
                if (b == BYTE_ID3_I) begin
                    sn_phase = SN_TAG;
                    return -1;
                end
                if (b == BYTE_SYNC) begin
                    sn_phase = SN_HDR1;
                    return -1;
                end
                return 0;
            end
            SN_TAG: begin
                if (idx > 4'd9) return 0;
                sn_hdr[idx] = b;
                if (idx == 4'd1 && b != BYTE_ID3_D) return 0;
                if (idx == 4'd2 && b != BYTE_ID3_3) return 0;
                if ((idx == 4'd3 || idx == 4'd4) && b == 8'hff) return 0;
                if (idx >= 4'd6 && idx <= 4'd8 && b[7]) return 0;
                if (idx < 4'd9) begin
                    sn_pos = idx + 4'd1;
                    return -1;
                end
                body = longint'(b) | (longint'(sn_hdr[8]) << 7) |
                       (longint'(sn_hdr[7]) << 14) | (longint'(sn_hdr[6]) << 21);
                cap = (64'd1 << SKIP_BITS_DEFAULT) - 64'd1;
                sn_skip = (body > cap) ? cap[SKIP_BITS_DEFAULT-1:0]
                                       : body[SKIP_BITS_DEFAULT-1:0];
                sn_pos = 4'd0;
                sn_phase = (sn_skip == 0) ? SN_START : SN_TAGSKIP;
                return -1;
            end
            SN_TAGSKIP: begin
                if (sn_skip > 0) sn_skip = sn_skip - 1'b1;
                if (sn_skip == 0) sn_phase = SN_START;
                return -1;
            end
            SN_HDR1: begin
                if (idx > 4'd3 || !sync_byte_ok(idx, b)) return 0;
                sn_hdr[idx] = b;
                if (idx == 4'd2) begin
                    nbytes = frame_bytes(sn_hdr[1], b);
                    sn_flen = nbytes[10:0];
                    if (sn_flen < 11'd4) return 0;
                end
                if (idx < 4'd3) begin
                    sn_pos = idx + 4'd1;
                    return -1;
                end
                sn_pos = 4'd0;
                sn_flen = sn_flen - 11'd4;
                sn_phase = (sn_flen == 0) ? SN_HDR2 : SN_FRAMESKIP;
                return -1;
            end
            SN_FRAMESKIP: begin
                if (sn_flen > 0) sn_flen = sn_flen - 11'd1;
                if (sn_flen == 0) begin
                    sn_phase = SN_HDR2;
                    sn_pos = 4'd0;
                end
                return -1;
            end
            SN_HDR2: begin
                if (idx > 4'd3 || !sync_byte_ok(idx, b)) return 0;
                sn_hdr[idx] = b;
                if (idx < 4'd3) begin
                    sn_pos = idx + 4'd1;
                    return -1;
                end
                sn_phase = SN_TAIL;
                return -1;
            end
            SN_TAIL: return 1;
            default: return 0;
        endcase
    endfunction

    task automatic sniff_byte(input logic [7:0] b, input logic last);
        int v;
        if (sn_decided) begin
            if (last) sniff_clear();
            return;
        end
        v = sniff_consume(b);
        if (v < 0 && last) v = 0;
        if (v >= 0) begin
            verdicts_due.push_back(v[0]);
            sniff_clear();
            sn_decided = !last;
        end
    endtask

    task automatic note_failure(input string msg);
        if (fail_count < 10) $display("%s", msg);
        fail_count++;
    endtask

    task automatic feed_buffer(input logic [7:0] bytes [$], input traffic_t mode);
        sniff_item_t it;
        foreach (bytes[i]) begin
            it.data = bytes[i];
            it.last = (i == bytes.size() - 1);
            it.mode = mode;
            byte_feed.push_back(it);
        end
    endtask

    // Frame header bytes, first byte in the lowest bits.
    function automatic logic [31:0] rand_header(input bit long_ok);
        logic [1:0] ver;
        logic [1:0] fidx;
        logic [3:0] bidx;
        if (long_ok) begin
            ver  = 2'($urandom_range(3));
            bidx = 4'($urandom_range(1, 14));
        end else begin
            ver  = ($urandom_range(3) == 0) ? 2'd0 : 2'd2;
            bidx = 4'($urandom_range(1, 3));
        end
        fidx = 2'($urandom_range(2));
        return {8'($urandom), bidx, fidx, 2'($urandom_range(3)),
                3'b111, ver, 2'b01, 1'($urandom_range(1)), BYTE_SYNC};
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) sniff_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                gap_pct = (traffic_mode == TRAFFIC_SEND_GAPS) ? 64 :
                          (traffic_mode == TRAFFIC_BOTH) ? 20 : 0;
                if (byte_feed.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    drv_item = byte_feed.pop_front();
                    s_tdata      <= drv_item.data;
                    s_tlast      <= drv_item.last;
                    traffic_mode <= drv_item.mode;
                    s_tvalid     <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (verdicts_due.size() == 0) begin
                note_failure($sformatf("unexpected verdict transaction, m_tdata %02h",
                                       m_tdata));
            end else begin
                want_verdict = verdicts_due.pop_front();
                if (m_tdata !== {7'b0, want_verdict}) begin
                    note_failure($sformatf("verdict mismatch: expected %0d, got m_tdata %02h",
                                           want_verdict, m_tdata));
                end
            end
        end
        stall_pct = (traffic_mode == TRAFFIC_RECV_STALLS) ? 64 :
                    (traffic_mode == TRAFFIC_BOTH) ? 20 : 0;
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [7:0]  buf_q [$];
        logic [31:0] hdr;
        int          rand_bytes;
        int          kind;
        int          ntags;
        int          body;
        int          flen;
        int          cut;
        int          pos;
        logic [7:0]  size8;
        logic [7:0]  size9;
        bit          long_ok;

        sniff_clear();
        rand_bytes = 0;

        buf_q = {8'h00};
        feed_buffer(buf_q, TRAFFIC_FULL);
        buf_q = {8'h12, 8'h34, 8'h56};
        feed_buffer(buf_q, TRAFFIC_FULL);
        buf_q = {BYTE_SYNC, 8'he2, 8'h04, 8'h55};
        feed_buffer(buf_q, TRAFFIC_FULL);
        buf_q = {BYTE_SYNC, 8'hff};
        feed_buffer(buf_q, TRAFFIC_FULL);
        buf_q = {BYTE_ID3_I, BYTE_ID3_D, BYTE_ID3_3, 8'hff};
        feed_buffer(buf_q, TRAFFIC_FULL);
        buf_q = {BYTE_ID3_I, BYTE_ID3_D, BYTE_ID3_3, 8'h04, 8'h00,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        feed_buffer(buf_q, TRAFFIC_FULL);

        while (rand_bytes < 600) begin
            buf_q.delete();
            kind = $urandom_range(99);
            if (kind < 25) begin
                repeat ($urandom_range(1, 6)) buf_q.push_back(8'($urandom));
            end else if (kind < 40) begin
                // A tag with arbitrary size bytes, cut off well before its body ends.
                buf_q = {BYTE_ID3_I, BYTE_ID3_D, BYTE_ID3_3};
                repeat (3) buf_q.push_back(8'($urandom));
                repeat (3) buf_q.push_back(8'($urandom) & ($urandom_range(1) ? 8'hff : 8'h7f));
                repeat ($urandom_range(1, 8)) buf_q.push_back(8'($urandom));
            end else begin
                kind  = $urandom_range(9);
                ntags = (kind < 6) ? 0 : (kind < 9) ? 1 : 2;
                repeat (ntags) begin
                    size8 = ($urandom_range(7) == 0) ? 8'h01 : 8'h00;
                    size9 = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(1, 40));
                    buf_q.push_back(BYTE_ID3_I);
                    buf_q.push_back(BYTE_ID3_D);
                    buf_q.push_back(BYTE_ID3_3);
                    buf_q.push_back(8'($urandom_range(254)));
                    buf_q.push_back(8'($urandom_range(254)));
                    buf_q.push_back(8'($urandom));
                    buf_q.push_back(8'h00);
                    buf_q.push_back(8'h00);
                    buf_q.push_back(size8);
                    buf_q.push_back(size9);
                    body = int'(size9) | (int'(size8) << 7);
                    repeat (body) buf_q.push_back(8'($urandom));
                end
                long_ok = (long_frames < 3) && ($urandom_range(19) == 0);
                if (long_ok) long_frames++;
                do begin
                    hdr  = rand_header(long_ok);
                    flen = int'(frame_bytes(hdr[15:8], hdr[23:16]));
                end while (flen > 200);
                for (int i = 0; i < 4; i++) buf_q.push_back(hdr[8*i +: 8]);
                repeat (flen - 4) buf_q.push_back(8'($urandom));
                hdr = rand_header(1'b1);
                for (int i = 0; i < 4; i++) buf_q.push_back(hdr[8*i +: 8]);
                repeat ($urandom_range(1, 3)) buf_q.push_back(8'($urandom));
                if (kind < 60 && $urandom_range(1) == 1) begin
                    case ($urandom_range(2))
                        0: begin
                            cut = $urandom_range(1, buf_q.size());
                            while (buf_q.size() > cut) void'(buf_q.pop_back());
                        end
                        1: begin
                            pos = $urandom_range(buf_q.size() - 1);
                            buf_q[pos] = buf_q[pos] ^ (8'h01 << $urandom_range(7));
                        end
                        default: begin
                            pos = $urandom_range(buf_q.size() - 1);
                            buf_q[pos] = 8'($urandom);
                        end
                    endcase
                end
            end
            feed_buffer(buf_q, traffic_t'((rand_bytes / 150) % 4));
            rand_bytes += buf_q.size();
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (byte_feed.size() != 0 || s_tvalid || verdicts_due.size() != 0);
        repeat (20) @(negedge aclk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
